// File: rtl/stm_pkg.sv
// stm_pkg: shared types and constants for the stereo track mix-down block.
// Holds register map codes, gain slot layout, reciprocal constants and stage payloads.
// No dependencies.
package stm_pkg;

  // register map (index = paddr[5:3], 64-bit registers at 8-byte spacing)
  localparam int          ADDR_W        = 6;
  localparam int          DATA_W        = 64;
  localparam logic [2:0]  REG_ACTIVE    = 3'd0;
  localparam logic [2:0]  REG_MIX_0     = 3'd1;
  localparam logic [2:0]  REG_MIX_1     = 3'd2;
  localparam logic [2:0]  REG_MIX_2     = 3'd3;
  localparam logic [2:0]  REG_MIX_3     = 3'd4;

  localparam int          ACTIVE_W      = 5;
  localparam int          MIX_W         = 60;
  localparam int          POS_W         = 4;
  localparam int          SLOT_W        = 15;
  localparam int          GAIN_W        = 7;
  localparam int          SAMPLE_W      = 16;
  localparam int          QUOT_W        = 10;

  localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 5'd16;
  // four slots of 50/50 gain, muted
  localparam logic [MIX_W-1:0]    MIX_RESET    = 60'hB26564CAC995932;

  localparam logic [GAIN_W-1:0]   GAIN_MAX     = 7'd100;

  // x / 100 == (x * 41944) >> 22, exact for 0 <= x <= 43690
  localparam logic [15:0] DIV_RECIP     = 16'd41944;
  localparam int          DIV_SHIFT     = 22;

  // stage 1: raw sample with effective gains (clamped, mute folded in)
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic [GAIN_W-1:0]          gain_l;
    logic [GAIN_W-1:0]          gain_r;
    logic                       last;
  } stage1_t;

  // stage 2: sample / 100, truncated toward zero
  typedef struct packed {
    logic signed [QUOT_W-1:0]   quot;
    logic [GAIN_W-1:0]          gain_l;
    logic [GAIN_W-1:0]          gain_r;
    logic                       last;
  } stage2_t;

  // stage 3: wrapped per-side contributions
  typedef struct packed {
    logic [SAMPLE_W-1:0]        contrib_l;
    logic [SAMPLE_W-1:0]        contrib_r;
    logic                       last;
  } stage3_t;

endpackage

// File: rtl/stereo_track_mixdown.sv
// stereo_track_mixdown: each sample passes the registers input reg, divide, gain multiply and
// accumulate in order; the result register loads on a frame's last sample. Throughput: one sample
// per cycle while no frame result waits on a blocked output register; one result per frame.
// Reset (rst, synchronous, active high) empties the pipeline, clears channel position and both
// sums, and loads register defaults: 16 channels, all tracks 50/50 and muted.
// Depends on stm_pkg.
module stereo_track_mixdown #(
  parameter int TRACK_COUNT = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  // sample stream in
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [15:0]                   s_tdata,   // [15:0] sample
  // stereo result out
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [31:0]                   m_tdata,   // [15:0] left_out, [31:16] right_out
  // configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [stm_pkg::ADDR_W-1:0]    paddr,
  input  logic [stm_pkg::DATA_W-1:0]    pwdata,
  output logic [stm_pkg::DATA_W-1:0]    prdata,
  output logic                          pready
);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [stm_pkg::ACTIVE_W-1:0] active_channels;
  logic [stm_pkg::MIX_W-1:0]    mix_word_0;
  logic [stm_pkg::MIX_W-1:0]    mix_word_1;
  logic [stm_pkg::MIX_W-1:0]    mix_word_2;
  logic [stm_pkg::MIX_W-1:0]    mix_word_3;

  logic       cfg_write;
  logic [2:0] cfg_index;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign cfg_index = paddr[5:3];

  always_ff @(posedge clk) begin
    if (rst) begin
      active_channels <= stm_pkg::ACTIVE_RESET;
      mix_word_0      <= stm_pkg::MIX_RESET;
      mix_word_1      <= stm_pkg::MIX_RESET;
      mix_word_2      <= stm_pkg::MIX_RESET;
      mix_word_3      <= stm_pkg::MIX_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        stm_pkg::REG_ACTIVE: active_channels <= pwdata[stm_pkg::ACTIVE_W-1:0];
        stm_pkg::REG_MIX_0:  mix_word_0      <= pwdata[stm_pkg::MIX_W-1:0];
        stm_pkg::REG_MIX_1:  mix_word_1      <= pwdata[stm_pkg::MIX_W-1:0];
        stm_pkg::REG_MIX_2:  mix_word_2      <= pwdata[stm_pkg::MIX_W-1:0];
        stm_pkg::REG_MIX_3:  mix_word_3      <= pwdata[stm_pkg::MIX_W-1:0];
        default: ;  // unmapped, write dropped
      endcase
    end
  end

  always_comb begin
    unique case (cfg_index)
      stm_pkg::REG_ACTIVE: prdata = {{(stm_pkg::DATA_W-stm_pkg::ACTIVE_W){1'b0}},
                                     active_channels};
      stm_pkg::REG_MIX_0:  prdata = {{(stm_pkg::DATA_W-stm_pkg::MIX_W){1'b0}}, mix_word_0};
      stm_pkg::REG_MIX_1:  prdata = {{(stm_pkg::DATA_W-stm_pkg::MIX_W){1'b0}}, mix_word_1};
      stm_pkg::REG_MIX_2:  prdata = {{(stm_pkg::DATA_W-stm_pkg::MIX_W){1'b0}}, mix_word_2};
      stm_pkg::REG_MIX_3:  prdata = {{(stm_pkg::DATA_W-stm_pkg::MIX_W){1'b0}}, mix_word_3};
      default:             prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Handshake chain: a stall only starts at the accumulator, when a frame
  // result is ready but the output register still holds the previous one.
  // ---------------------------------------------------------------------------
  logic              r1_valid, r2_valid, r3_valid;
  stm_pkg::stage1_t  r1;
  stm_pkg::stage2_t  r2;
  stm_pkg::stage3_t  r3;

  logic acc_ready, r3_ready, r2_ready;
  logic acc_take, in_take;

  assign acc_ready = !(r3.last && m_tvalid && !m_tready);
  assign acc_take  = r3_valid && acc_ready;
  assign r3_ready  = !r3_valid || acc_ready;
  assign r2_ready  = !r2_valid || r3_ready;
  assign s_tready  = !r1_valid || r2_ready;
  assign in_take   = s_tvalid && s_tready;

  // ---------------------------------------------------------------------------
  // Channel position and gain slot lookup at the input
  // ---------------------------------------------------------------------------
  localparam logic [stm_pkg::ACTIVE_W-1:0] TRACK_MAX = stm_pkg::ACTIVE_W'(TRACK_COUNT);

  logic [stm_pkg::POS_W-1:0]    pos;
  logic [stm_pkg::ACTIVE_W-1:0] frame_len;
  logic [stm_pkg::ACTIVE_W-1:0] pos_inc;
  logic                         in_last;
  logic [stm_pkg::MIX_W-1:0]    word_sel;
  logic [stm_pkg::SLOT_W-1:0]   slot;
  logic [stm_pkg::GAIN_W-1:0]   raw_l, raw_r;
  logic                         mute;
  stm_pkg::stage1_t             r1_next;

  always_comb begin
    // zero channels behaves as one; more than the track count saturates
    if (active_channels == '0)          frame_len = stm_pkg::ACTIVE_W'(1);
    else if (active_channels > TRACK_MAX) frame_len = TRACK_MAX;
    else                                frame_len = active_channels;
  end

  // a position at or past the last channel (count lowered mid-frame) ends the frame
  assign pos_inc = {1'b0, pos} + stm_pkg::ACTIVE_W'(1);
  assign in_last = pos_inc >= frame_len;

  always_comb begin
    case (pos[3:2])
      2'd0:    word_sel = mix_word_0;
      2'd1:    word_sel = mix_word_1;
      2'd2:    word_sel = mix_word_2;
      default: word_sel = mix_word_3;
    endcase
    case (pos[1:0])
      2'd0:    slot = word_sel[14:0];
      2'd1:    slot = word_sel[29:15];
      2'd2:    slot = word_sel[44:30];
      default: slot = word_sel[59:45];
    endcase
  end

  assign raw_l = slot[6:0];
  assign raw_r = slot[13:7];
  assign mute  = slot[14];

  always_comb begin
    r1_next.sample = $signed(s_tdata);
    r1_next.last   = in_last;
    // mute folds into a zero gain; gains over 100 percent clamp
    if (mute)                             r1_next.gain_l = '0;
    else if (raw_l > stm_pkg::GAIN_MAX)   r1_next.gain_l = stm_pkg::GAIN_MAX;
    else                                  r1_next.gain_l = raw_l;
    if (mute)                             r1_next.gain_r = '0;
    else if (raw_r > stm_pkg::GAIN_MAX)   r1_next.gain_r = stm_pkg::GAIN_MAX;
    else                                  r1_next.gain_r = raw_r;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else if (in_take) begin
      pos <= in_last ? '0 : pos_inc[stm_pkg::POS_W-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1 register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      r1_valid <= 1'b0;
    end else if (s_tready) begin
      r1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      r1 <= r1_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: divide by 100 toward zero via reciprocal multiply on the magnitude
  // ---------------------------------------------------------------------------
  logic [15:0]                      mag;
  logic [31:0]                      recip_prod;
  logic [stm_pkg::QUOT_W-1:0]       quot_mag;
  stm_pkg::stage2_t                 r2_next;

  assign mag        = r1.sample[15] ? (~r1.sample + 16'd1) : r1.sample;
  assign recip_prod = {16'd0, mag} * {16'd0, stm_pkg::DIV_RECIP};
  assign quot_mag   = recip_prod[stm_pkg::DIV_SHIFT +: stm_pkg::QUOT_W];

  always_comb begin
    r2_next.quot   = r1.sample[15] ? $signed(-quot_mag) : $signed(quot_mag);
    r2_next.gain_l = r1.gain_l;
    r2_next.gain_r = r1.gain_r;
    r2_next.last   = r1.last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      r2_valid <= 1'b0;
    end else if (r2_ready) begin
      r2_valid <= r1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (r2_ready && r1_valid) begin
      r2 <= r2_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: gain multiplies, kept to 16 bits (wrap)
  // ---------------------------------------------------------------------------
  logic signed [15:0]  prod_l, prod_r;
  stm_pkg::stage3_t    r3_next;

  assign prod_l = 16'(r2.quot) * 16'($signed({1'b0, r2.gain_l}));
  assign prod_r = 16'(r2.quot) * 16'($signed({1'b0, r2.gain_r}));

  always_comb begin
    r3_next.contrib_l = prod_l;
    r3_next.contrib_r = prod_r;
    r3_next.last      = r2.last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      r3_valid <= 1'b0;
    end else if (r3_ready) begin
      r3_valid <= r2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (r3_ready && r2_valid) begin
      r3 <= r3_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Accumulate and result register
  // ---------------------------------------------------------------------------
  logic [15:0] left_sum, right_sum;
  logic [15:0] left_sum_next, right_sum_next;

  assign left_sum_next  = left_sum  + r3.contrib_l;
  assign right_sum_next = right_sum + r3.contrib_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      left_sum  <= '0;
      right_sum <= '0;
    end else if (acc_take) begin
      left_sum  <= r3.last ? '0 : left_sum_next;
      right_sum <= r3.last ? '0 : right_sum_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (acc_take && r3.last) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc_take && r3.last) begin
      m_tdata <= {right_sum_next, left_sum_next};
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // input back-pressure only ever comes from a blocked result register
  a_stall_source: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (m_tvalid && !m_tready))
    else $error("input stalled without a blocked result");

  // a frame end clears both sums
  a_sum_clear: assert property (@(posedge clk) disable iff (rst)
    (acc_take && r3.last) |=> (left_sum == '0 && right_sum == '0))
    else $error("sums not cleared after frame end");

  // the last channel of a frame wraps the position back to zero
  a_pos_wrap: assert property (@(posedge clk) disable iff (rst)
    (in_take && in_last) |=> (pos == '0))
    else $error("channel position did not wrap");

  // a new result appears only from a frame end in the accumulator
  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(acc_take && r3.last))
    else $error("result without frame end");

endmodule

// File: tb/sv/stereo_track_mixdown_tb.sv
`timescale 1ns / 100ps
// stereo_track_mixdown_tb: self-checking bench for the stereo track mix-down block.
// Streams samples with random idle bursts on both sides, predicts every frame with an
// in-bench mix model. Depends on stm_pkg and the stereo_track_mixdown RTL.
module stereo_track_mixdown_tb;

  localparam int            TRACKS         = 16;
  localparam int            DIVISOR        = 100;
  localparam int            GAIN_CAP       = 100;
  localparam logic [4:0]    ACTIVE_DEFAULT = 5'd16;
  localparam logic [59:0]   MIX_DEFAULT    = 60'hB26564CAC995932;
  // first index past the register map; writes there must be dropped
  localparam logic [2:0]    REG_SPARE      = 3'd5;
  // pipeline is 4 deep; PIPE_FLUSH waits for it to empty after the last transaction
  localparam int            PIPE_FLUSH     = 8;
  localparam int            RANDOM_ITEMS   = 1700;

  typedef struct packed {
    logic [15:0] left;
    logic [15:0] right;
  } stereo_t;

  // ---------------------------------------------------------------------------
  // DUT signals, all inputs known from time zero
  // ---------------------------------------------------------------------------
  logic                       clk;
  logic                       rst      = 1'b1;
  logic                       s_tvalid = 1'b0;
  logic                       s_tready;
  logic [15:0]                s_tdata  = '0;   // [15:0] sample
  logic                       m_tvalid;
  logic                       m_tready = 1'b0;
  logic [31:0]                m_tdata;         // [15:0] left_out, [31:16] right_out
  logic                       psel     = 1'b0;
  logic                       penable  = 1'b0;
  logic                       pwrite   = 1'b0;
  logic [stm_pkg::ADDR_W-1:0] paddr    = '0;
  logic [stm_pkg::DATA_W-1:0] pwdata   = '0;
  logic [stm_pkg::DATA_W-1:0] prdata;
  logic                       pready;

  stereo_track_mixdown #(
    .TRACK_COUNT(TRACKS)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Mix model: register copies plus frame state
  // ---------------------------------------------------------------------------
  logic [4:0]  active_cfg;
  logic [59:0] mix_cfg [4];
  logic [3:0]  track_pos;
  logic [15:0] left_acc;
  logic [15:0] right_acc;

  logic [15:0] pending_samples [$];   // driver feed
  stereo_t     mixed_frames [$];      // predicted frames, oldest first
  stereo_t     want;

  int samples_queued = 0;
  int samples_taken  = 0;
  int mismatches     = 0;
  int idle_pct       = 0;             // idle burst percent, per send or ready cycle
  int send_gap       = 0;
  int hold_gap       = 0;

  // one track's wrapped share: gain clamps at 100, mute or zero gain drops it
  function automatic logic [15:0] track_share(input int quot, input logic [6:0] gain,
                                              input logic mute);
    int g;
    g = (gain > GAIN_CAP) ? GAIN_CAP : int'(gain);
    if (mute || g == 0) return '0;
    return 16'(quot * g);
  endfunction

  // add one sample into the frame sums; closes the frame on the last active channel
  task automatic mix_sample(input logic [15:0] raw);
    int          quot;
    int          frame_len;
    logic [14:0] slot;
    quot      = $signed(raw) / DIVISOR;   // truncates toward zero
    slot      = 15'(mix_cfg[track_pos[3:2]] >> (15 * track_pos[1:0]));
    frame_len = (active_cfg == 0) ? 1 : (active_cfg > TRACKS) ? TRACKS : int'(active_cfg);
    left_acc  = left_acc + track_share(quot, slot[6:0], slot[14]);
    right_acc = right_acc + track_share(quot, slot[13:7], slot[14]);
    // a lowered channel count mid-frame ends the frame at once
    if (track_pos + 1 >= frame_len) begin
      mixed_frames.push_back('{left: left_acc, right: right_acc});
      left_acc  = '0;
      right_acc = '0;
      track_pos = '0;
    end else begin
      track_pos = track_pos + 1'b1;
    end
  endtask

  function automatic logic [14:0] slot_bits(input logic [6:0] gl, input logic [6:0] gr,
                                            input logic mute);
    return {mute, gr, gl};
  endfunction

  // gains lean on the clamp boundary and zero
  function automatic logic [6:0] pick_gain();
    case ($urandom_range(0, 5))
      0:       return 7'd0;
      1:       return 7'd100;
      2:       return 7'd127;
      3:       return 7'd101;
      default: return 7'($urandom);
    endcase
  endfunction

  // random packed word; bits above the 60-bit register stay random to test masking
  function automatic logic [63:0] random_mix_word();
    logic [63:0] w;
    w = {$urandom, $urandom};
    for (int k = 0; k < 4; k++)
      w[15*k +: 15] = slot_bits(pick_gain(), pick_gain(), $urandom_range(0, 3) == 0);
    return w;
  endfunction

  task automatic queue_sample(input logic [15:0] v);
    pending_samples.push_back(v);
    samples_queued++;
  endtask

  // setup then access cycle; model follows at the edge the write lands
  task automatic apb_write(input logic [2:0] idx, input logic [63:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == stm_pkg::REG_ACTIVE)
      active_cfg = value[4:0];
    else if (idx >= stm_pkg::REG_MIX_0 && idx <= stm_pkg::REG_MIX_3)
      mix_cfg[idx - stm_pkg::REG_MIX_0] = value[59:0];
  endtask

  // wait for every sample taken and every frame out, then let partial frames settle
  task automatic drain();
    while (samples_taken != samples_queued) @(posedge clk);
    while (mixed_frames.size() != 0) @(posedge clk);
    repeat (PIPE_FLUSH) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Sample driver: pulls from the pending queue, idles in bursts
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      send_gap <= 0;
    end else if (!s_tvalid || s_tready) begin
      if (send_gap != 0) begin
        s_tvalid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (pending_samples.size() != 0) begin
        s_tdata  <= pending_samples.pop_front();
        s_tvalid <= 1'b1;
        if ($urandom_range(0, 99) < idle_pct) send_gap <= $urandom_range(1, 16);
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // result sink: stalls in bursts
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      hold_gap <= 0;
    end else if (hold_gap != 0) begin
      m_tready <= 1'b0;
      hold_gap <= hold_gap - 1;
    end else begin
      m_tready <= 1'b1;
      if ($urandom_range(0, 99) < idle_pct) hold_gap <= $urandom_range(1, 16);
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: check the result transaction first, so a frame predicted at this
  // same edge is never matched against an older output
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (mixed_frames.size() == 0) begin
          $display("%0t: unexpected frame, expected none, got left %0d right %0d",
                   $time, $signed(m_tdata[15:0]), $signed(m_tdata[31:16]));
          mismatches++;
        end else begin
          want = mixed_frames.pop_front();
          if (m_tdata[15:0] !== want.left) begin
            $display("%0t: left_out mismatch, expected %0d, got %0d",
                     $time, $signed(want.left), $signed(m_tdata[15:0]));
            mismatches++;
          end
          if (m_tdata[31:16] !== want.right) begin
            $display("%0t: right_out mismatch, expected %0d, got %0d",
                     $time, $signed(want.right), $signed(m_tdata[31:16]));
            mismatches++;
          end
        end
      end
      // predict before counting, so drain() never sees a taken sample unpredicted
      if (s_tvalid && s_tready) begin
        mix_sample(s_tdata);
        samples_taken++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    int          random_sent;
    int          phase_len;
    bit          closing;
    logic [63:0] act;
    logic [15:0] smp;
    active_cfg = ACTIVE_DEFAULT;
    for (int t = 0; t < 4; t++) mix_cfg[t] = MIX_DEFAULT;
    track_pos = '0;
    left_acc  = '0;
    right_acc = '0;

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // default config: 16 channels, all muted, so one all-zero frame from the extremes
    queue_sample(16'h7FFF);   queue_sample(16'h8000);   queue_sample(16'h0000);
    queue_sample(16'hFFFF);   queue_sample(16'h0001);   queue_sample(16'd99);
    queue_sample(-16'sd99);   queue_sample(16'd100);    queue_sample(-16'sd100);
    queue_sample(16'd101);    queue_sample(-16'sd101);  queue_sample(16'd199);
    queue_sample(-16'sd199);  queue_sample(16'h5555);   queue_sample(16'hAAAA);
    queue_sample(16'd12345);
    drain();

    // four channels: plain 100, clamped gains, zero left gain, muted; top bits set
    apb_write(stm_pkg::REG_ACTIVE, 64'd4);
    apb_write(stm_pkg::REG_MIX_0, {4'hF, slot_bits(7'd100, 7'd100, 1'b1),
                                   slot_bits(7'd0, 7'd55, 1'b0),
                                   slot_bits(7'd127, 7'd101, 1'b0),
                                   slot_bits(7'd100, 7'd100, 1'b0)});
    queue_sample(16'h7FFF);  queue_sample(16'h8000);
    queue_sample(-16'sd200); queue_sample(16'd99);
    drain();

    // two full-scale channels: sums wrap both ways
    apb_write(stm_pkg::REG_ACTIVE, 64'd2);
    apb_write(stm_pkg::REG_MIX_0, {4'h0, slot_bits(7'd0, 7'd0, 1'b1),
                                   slot_bits(7'd0, 7'd0, 1'b1),
                                   slot_bits(7'd100, 7'd100, 1'b0),
                                   slot_bits(7'd100, 7'd100, 1'b0)});
    queue_sample(16'h7FFF); queue_sample(16'h7FFF);
    queue_sample(16'h8000); queue_sample(16'h8000);
    drain();

    // out-of-map write is dropped; zero channels acts as one
    apb_write(REG_SPARE + 3'($urandom_range(0, 2)), {$urandom, $urandom});
    apb_write(stm_pkg::REG_ACTIVE, 64'd0);
    queue_sample(16'h8000); queue_sample(16'h7FFF);
    drain();

    // count above 16 clamps; leave the frame open, then shrink the count under it
    apb_write(stm_pkg::REG_ACTIVE, 64'd31);
    queue_sample(16'd5000); queue_sample(-16'sd5000); queue_sample(16'd777);
    drain();
    apb_write(stm_pkg::REG_ACTIVE, 64'd2);
    queue_sample(16'd300);
    drain();

    // random phases, each with a fresh register set; the last one runs without idling
    random_sent = 0;
    while (random_sent < RANDOM_ITEMS) begin
      closing = (RANDOM_ITEMS - random_sent) <= 300;
      case ($urandom_range(0, 7))
        0:       act = 64'd0;
        1:       act = 64'd1;
        2:       act = 64'd16;
        3:       act = 64'($urandom_range(17, 31)) | {$urandom, 5'b0};
        default: act = 64'($urandom_range(1, 16));
      endcase
      apb_write(stm_pkg::REG_ACTIVE, act);
      for (int w = 0; w < 4; w++) apb_write(stm_pkg::REG_MIX_0 + 3'(w), random_mix_word());
      if ($urandom_range(0, 3) == 0)
        apb_write(REG_SPARE + 3'($urandom_range(0, 2)), {$urandom, $urandom});
      case ($urandom_range(0, 2))
        0:       idle_pct = 0;
        1:       idle_pct = 5;
        default: idle_pct = 15;
      endcase
      if (closing) idle_pct = 0;
      phase_len = closing ? RANDOM_ITEMS - random_sent : $urandom_range(120, 260);
      repeat (phase_len) begin
        smp = 16'($urandom);
        if ($urandom_range(0, 9) == 0) begin
          case ($urandom_range(0, 3))
            0:       smp = 16'h7FFF;
            1:       smp = 16'h8000;
            2:       smp = 16'h0000;
            default: smp = 16'hFFFF;
          endcase
        end
        queue_sample(smp);
      end
      random_sent += phase_len;
      drain();
    end

    if (mismatches == 0 && mixed_frames.size() == 0)
      $display("** stereo_track_mixdown: PASSED **");
    else
      $display("** stereo_track_mixdown: FAILED **");
    $finish;
  end

  // watchdog, far beyond the slowest correct run
  initial begin
    #10_000_000;
    $display("** stereo_track_mixdown: FAILED **");
    $finish;
  end

endmodule
